// ===== rtl/mcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpt_pkg
// Shared types and constants for the machine cycle phase timer.
// ----------------------------------------------------------------------------
package mcpt_pkg;

  localparam int LEVEL_W = 4;
  localparam int SEL_W   = 6;
  localparam int OUT_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_C = 2'd2;

  // one line: start and end condition, each a port and a level
  typedef struct packed {
    logic       end_level;
    logic [1:0] end_port;
    logic       start_level;
    logic [1:0] start_port;
  } line_sel_t;

  typedef struct packed {
    logic             emit;
    logic [OUT_W-1:0] forming_ticks;
    logic [OUT_W-1:0] fill_ticks;
    logic [OUT_W-1:0] machine_ticks;
    logic [OUT_W-1:0] cycle_count;
  } res_t;

endpackage

// ===== rtl/machine_cycle_phase_timer_top.sv =====
// ----------------------------------------------------------------------------
// machine_cycle_phase_timer_top
// Times machine cycles from three sequenced input lines, one sample a beat.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall   | input_levels, count_inhibit
//  out     | out_valid / out_stall | forming/fill/machine_ticks, cycle_count
//  cfg     | cfg_we                | cfg_index, cfg_data
//
//  One sample a cycle while in_stall is low; a sample is held in the
//  input register, then the sequencer updates and any result lands in
//  the output register.
//  Synchronous reset clears phase, counters, stamps and selects.
//  A result held under out_stall blocks only the sample register behind it.
// ----------------------------------------------------------------------------
module machine_cycle_phase_timer_top #(
  parameter int TIME_WIDTH  = 32,
  parameter int INPUT_PORTS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mcpt_pkg::LEVEL_W-1:0]     input_levels,
  input  logic                             count_inhibit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mcpt_pkg::OUT_W-1:0]       forming_ticks,
  output logic [mcpt_pkg::OUT_W-1:0]       fill_ticks,
  output logic [mcpt_pkg::OUT_W-1:0]       machine_ticks,
  output logic [mcpt_pkg::OUT_W-1:0]       cycle_count,
  input  logic                             cfg_we,
  input  logic [mcpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcpt_pkg::SEL_W-1:0]       cfg_data
);

  mcpt_pkg::line_sel_t sel_a, sel_b, sel_c;

  logic                   s1_valid;
  logic [INPUT_PORTS-1:0] s1_levels;
  logic                   s1_inhibit;
  logic                   out_blocked;
  logic                   s1_go;
  logic                   in_take;
  mcpt_pkg::res_t         res;

  // unused ports read as level 0
  logic [mcpt_pkg::LEVEL_W-1:0] levels_pad;
  assign levels_pad = mcpt_pkg::LEVEL_W'(s1_levels);

  assign out_blocked = out_valid && out_stall;
  assign s1_go       = s1_valid && !out_blocked;
  assign in_stall    = s1_valid && out_blocked;
  assign in_take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_a <= '0;
      sel_b <= '0;
      sel_c <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcpt_pkg::CFG_LINE_A: sel_a <= mcpt_pkg::line_sel_t'(cfg_data);
        mcpt_pkg::CFG_LINE_B: sel_b <= mcpt_pkg::line_sel_t'(cfg_data);
        mcpt_pkg::CFG_LINE_C: sel_c <= mcpt_pkg::line_sel_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_levels  <= input_levels[INPUT_PORTS-1:0];
      s1_inhibit <= count_inhibit;
    end
  end

  mcpt_seq #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_go),
    .levels  (levels_pad),
    .inhibit (s1_inhibit),
    .sel_a   (sel_a),
    .sel_b   (sel_b),
    .sel_c   (sel_c),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= res.emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.emit) begin
      forming_ticks <= res.forming_ticks;
      fill_ticks    <= res.fill_ticks;
      machine_ticks <= res.machine_ticks;
      cycle_count   <= res.cycle_count;
    end
  end

endmodule

// ===== rtl/mcpt_seq.sv =====
// ----------------------------------------------------------------------------
// mcpt_seq
// Six-phase line sequencer with tick counter, stamps and cycle counter.
// ----------------------------------------------------------------------------
module mcpt_seq #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [mcpt_pkg::LEVEL_W-1:0] levels,
  input  logic                        inhibit,
  input  mcpt_pkg::line_sel_t         sel_a,
  input  mcpt_pkg::line_sel_t         sel_b,
  input  mcpt_pkg::line_sel_t         sel_c,
  output mcpt_pkg::res_t              res
);

  localparam logic [2:0] PH_A_START = 3'd0;
  localparam logic [2:0] PH_A_END   = 3'd1;
  localparam logic [2:0] PH_B_START = 3'd2;
  localparam logic [2:0] PH_B_END   = 3'd3;
  localparam logic [2:0] PH_C_START = 3'd4;
  localparam logic [2:0] PH_C_END   = 3'd5;

  localparam int EXT_W = (TIME_WIDTH > mcpt_pkg::OUT_W) ? TIME_WIDTH : mcpt_pkg::OUT_W;

  logic [2:0]                  phase, phase_next;
  logic                        first_cycle, first_cycle_next;
  logic [TIME_WIDTH-1:0]       tick_now;
  logic [TIME_WIDTH-1:0]       stamp_a_start, stamp_a_start_next;
  logic [TIME_WIDTH-1:0]       stamp_b_start, stamp_b_start_next;
  logic [TIME_WIDTH-1:0]       stamp_b_end, stamp_b_end_next;
  logic [TIME_WIDTH-1:0]       stamp_c_end, stamp_c_end_next;
  logic [mcpt_pkg::OUT_W-1:0]  cycles_counted;
  logic [mcpt_pkg::OUT_W-1:0]  cycles_inc;

  logic                  hit;
  logic                  emit;
  logic [TIME_WIDTH-1:0] d_forming, d_fill, d_machine;
  logic [EXT_W-1:0]      x_forming, x_fill, x_machine;

  always_comb begin
    unique case (phase)
      PH_A_START: hit = levels[sel_a.start_port] == sel_a.start_level;
      PH_A_END:   hit = levels[sel_a.end_port]   == sel_a.end_level;
      PH_B_START: hit = levels[sel_b.start_port] == sel_b.start_level;
      PH_B_END:   hit = levels[sel_b.end_port]   == sel_b.end_level;
      PH_C_START: hit = levels[sel_c.start_port] == sel_c.start_level;
      PH_C_END:   hit = levels[sel_c.end_port]   == sel_c.end_level;
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    first_cycle_next   = first_cycle;
    stamp_a_start_next = stamp_a_start;
    stamp_b_start_next = stamp_b_start;
    stamp_b_end_next   = stamp_b_end;
    stamp_c_end_next   = stamp_c_end;
    emit               = 1'b0;
    unique case (phase)
      PH_A_START: begin
        if (hit) begin
          emit               = !first_cycle && !inhibit;
          first_cycle_next   = 1'b0;
          stamp_a_start_next = tick_now;
          phase_next         = PH_A_END;
        end
      end
      PH_A_END:   if (hit) phase_next = PH_B_START;
      PH_B_START: begin
        if (hit) begin
          stamp_b_start_next = tick_now;
          phase_next         = PH_B_END;
        end
      end
      PH_B_END: begin
        if (hit) begin
          stamp_b_end_next = tick_now;
          phase_next       = PH_C_START;
        end
      end
      PH_C_START: if (hit) phase_next = PH_C_END;
      PH_C_END: begin
        if (hit) begin
          stamp_c_end_next = tick_now;
          phase_next       = PH_A_START;
        end
      end
      default:    phase_next = PH_A_START;
    endcase
  end

  assign cycles_inc = cycles_counted + 1'b1;
  assign d_forming  = tick_now - stamp_a_start;
  assign d_fill     = stamp_b_end - stamp_b_start;
  assign d_machine  = stamp_c_end - stamp_a_start;
  assign x_forming  = EXT_W'(d_forming);
  assign x_fill     = EXT_W'(d_fill);
  assign x_machine  = EXT_W'(d_machine);

  assign res.emit          = emit;
  assign res.forming_ticks = x_forming[mcpt_pkg::OUT_W-1:0];
  assign res.fill_ticks    = x_fill[mcpt_pkg::OUT_W-1:0];
  assign res.machine_ticks = x_machine[mcpt_pkg::OUT_W-1:0];
  assign res.cycle_count   = cycles_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_A_START;
      first_cycle    <= 1'b1;
      tick_now       <= '0;
      stamp_a_start  <= '0;
      stamp_b_start  <= '0;
      stamp_b_end    <= '0;
      stamp_c_end    <= '0;
      cycles_counted <= '0;
    end else if (step) begin
      phase         <= phase_next;
      first_cycle   <= first_cycle_next;
      tick_now      <= tick_now + 1'b1;
      stamp_a_start <= stamp_a_start_next;
      stamp_b_start <= stamp_b_start_next;
      stamp_b_end   <= stamp_b_end_next;
      stamp_c_end   <= stamp_c_end_next;
      if (emit) cycles_counted <= cycles_inc;
    end
  end

endmodule
